@@ sv/json_value_extent_scanner_macros.svh @@
// Assertion macros used by the checker file jves_checker.sv.
`ifndef JSON_VALUE_EXTENT_SCANNER_MACROS_SVH
`define JSON_VALUE_EXTENT_SCANNER_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define JVES_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define JVES_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define JVES_ASSERT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/jves_pkg.sv @@
package jves_pkg;

   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam logic [7:0] MAX_DEPTH_RESET = 8'd128;

   // Characters that steer the scan
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
   localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;

   // Result status codes
   localparam logic [2:0] ST_FOUND = 3'd0;
   localparam logic [2:0] ST_EMPTY = 3'd1;
   localparam logic [2:0] ST_ENDED = 3'd2;
   localparam logic [2:0] ST_DEEP  = 3'd3;
   localparam logic [2:0] ST_LONG  = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] value_length;
   } rsp_type;

   typedef struct packed {
      logic    emit;
      rsp_type beat;
   } scan_result_type;

   function automatic logic is_open(input logic [7:0] c);
      return (c == CHAR_LBRACE) || (c == CHAR_LBRACKET);
   endfunction

   function automatic logic is_close(input logic [7:0] c);
      return (c == CHAR_RBRACE) || (c == CHAR_RBRACKET);
   endfunction

   function automatic logic ends_scalar(input logic [7:0] c);
      return (c == CHAR_COMMA) || is_close(c) || (c == CHAR_SPACE) || (c == CHAR_TAB) ||
             (c == CHAR_LF) || (c == CHAR_CR);
   endfunction

endpackage

@@ sv/json_value_extent_scanner.sv @@
// A beat accepted into the input register is taken from there by the scan step; the
//   result it ends with is loaded into the result register and shown on rsp_ ports.
// Throughput: one byte per cycle while the result register is not held by a stalled
//   consumer, with the scan step between the input register and the result register.
// Reset (synchronous, active high): scan goes idle, both registers empty,
//   max_depth returns to 128.
module json_value_extent_scanner #(
   parameter int LENGTH_BITS = jves_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   // byte channel
   input  logic              req_valid,
   output logic              req_ready,
   input  jves_pkg::req_type req_beat,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output jves_pkg::rsp_type rsp_beat,
   // max_depth register
   input  logic              csr_write_enable,
   input  logic [7:0]        csr_write_data
);

   // Input register: holds one accepted byte until the scan step takes it.
   logic              in_valid_ff, in_valid_in;
   jves_pkg::req_type in_beat_ff;

   // Result register: parts the scan from a stalled consumer.
   logic              out_valid_ff, out_valid_in;
   jves_pkg::rsp_type out_beat_ff, out_beat_in;

   logic [7:0] max_depth_ff;

   logic                      step;
   jves_pkg::scan_result_type result;

   // Advance the step when a byte waits and the result register has room for
   // whatever that byte may produce (empty now, or emptied at this edge).
   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   // Take a new byte whenever the input register is empty or drains this cycle.
   assign req_ready = !in_valid_ff || step;

   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_beat_in  = out_beat_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      // Load a fresh result; only bytes that end a scan produce one
      if (step && result.emit) begin
         out_valid_in = 1'b1;
         out_beat_in  = result.beat;
      end
   end

   jves_scan #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .item     (in_beat_ff),
      .max_depth(max_depth_ff),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_depth_ff <= jves_pkg::MAX_DEPTH_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         // The user must write it only while the scanner is quiet; the block does not enforce this
         if (csr_write_enable) begin
            max_depth_ff <= csr_write_data;
         end
      end
   end

   // Payload registers: no reset needed
   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_beat_ff <= req_beat;
      end
      out_beat_ff <= out_beat_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_beat  = out_beat_ff;

endmodule

@@ sv/jves_scan.sv @@
module jves_scan #(
   parameter int LENGTH_BITS = jves_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  jves_pkg::req_type         item,
   input  logic [7:0]                max_depth,
   output jves_pkg::scan_result_type result
);

   localparam logic [2:0] MODE_IDLE     = 3'd0;
   localparam logic [2:0] MODE_SCALAR   = 3'd1;
   localparam logic [2:0] MODE_STR      = 3'd2;
   localparam logic [2:0] MODE_STR_ESC  = 3'd3;
   localparam logic [2:0] MODE_CONT     = 3'd4;
   localparam logic [2:0] MODE_CONT_STR = 3'd5;
   localparam logic [2:0] MODE_CONT_ESC = 3'd6;

   localparam logic [LENGTH_BITS-1:0] COUNT_ONE = {{(LENGTH_BITS-1){1'b0}}, 1'b1};

   logic [2:0]             mode_ff,  mode_in;
   logic [7:0]             depth_ff, depth_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;

   always_comb begin
      logic [7:0]             c;
      logic                   done;
      logic [LENGTH_BITS-1:0] len;
      logic [2:0]             status;
      c        = item.data_byte;
      done     = 1'b0;
      len      = '0;
      status   = jves_pkg::ST_FOUND;
      mode_in  = mode_ff;
      depth_in = depth_ff;
      count_in = count_ff;

      if (item.first_byte) begin
         depth_in = '0;
         count_in = COUNT_ONE;
         if (c == jves_pkg::CHAR_QUOTE) begin
            mode_in = MODE_STR;
         end else if (jves_pkg::is_open(c)) begin
            if (max_depth == 8'd0) begin
               done   = 1'b1;
               status = jves_pkg::ST_DEEP;
            end else begin
               depth_in = 8'd1;
               mode_in  = MODE_CONT;
            end
         end else if (jves_pkg::ends_scalar(c)) begin
            done   = 1'b1;
            status = jves_pkg::ST_EMPTY;
         end else begin
            mode_in = MODE_SCALAR;
         end
      end else if (mode_ff == MODE_IDLE) begin
         // idle byte: dropped, last_byte with it
      end else if ((mode_ff == MODE_SCALAR) && jves_pkg::ends_scalar(c)) begin
         done   = 1'b1;
         status = jves_pkg::ST_FOUND;
         len    = count_ff;
      end else if (&count_ff) begin
         done   = 1'b1;
         status = jves_pkg::ST_LONG;
      end else begin
         count_in = count_ff + COUNT_ONE;
         case (mode_ff)
            MODE_SCALAR: begin
            end
            MODE_STR: begin
               if (c == jves_pkg::CHAR_BACKSLASH) begin
                  mode_in = MODE_STR_ESC;
               end else if (c == jves_pkg::CHAR_QUOTE) begin
                  done   = 1'b1;
                  status = jves_pkg::ST_FOUND;
                  len    = count_in;
               end
            end
            MODE_STR_ESC: begin
               mode_in = MODE_STR;
            end
            MODE_CONT: begin
               if (c == jves_pkg::CHAR_QUOTE) begin
                  mode_in = MODE_CONT_STR;
               end else if (jves_pkg::is_open(c)) begin
                  if (depth_ff >= max_depth) begin
                     done   = 1'b1;
                     status = jves_pkg::ST_DEEP;
                  end else begin
                     depth_in = depth_ff + 8'd1;
                  end
               end else if (jves_pkg::is_close(c)) begin
                  depth_in = depth_ff - 8'd1;
                  if (depth_in == 8'd0) begin
                     done   = 1'b1;
                     status = jves_pkg::ST_FOUND;
                     len    = count_in;
                  end
               end
            end
            MODE_CONT_STR: begin
               if (c == jves_pkg::CHAR_BACKSLASH) begin
                  mode_in = MODE_CONT_ESC;
               end else if (c == jves_pkg::CHAR_QUOTE) begin
                  mode_in = MODE_CONT;
               end
            end
            MODE_CONT_ESC: begin
               mode_in = MODE_CONT_STR;
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end

      // text ran out with the value still open
      if (!done && item.last_byte && (mode_in != MODE_IDLE)) begin
         done = 1'b1;
         if (mode_in == MODE_SCALAR) begin
            status = jves_pkg::ST_FOUND;
            len    = count_in;
         end else begin
            status = jves_pkg::ST_ENDED;
         end
      end

      // a result closes the scan
      if (done || (mode_in == MODE_IDLE)) begin
         mode_in  = MODE_IDLE;
         depth_in = '0;
         count_in = '0;
      end

      result.emit              = done;
      result.beat.status       = status;
      result.beat.value_length = (status == jves_pkg::ST_FOUND) ? 16'(len) : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         depth_ff <= '0;
         count_ff <= '0;
      end else if (step) begin
         mode_ff  <= mode_in;
         depth_ff <= depth_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ sv/jves_checker.sv @@
`include "json_value_extent_scanner_macros.svh"

module jves_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input jves_pkg::rsp_type rsp_beat
);

   `JVES_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_beat), "rsp beat dropped or changed while stalled")
   `JVES_ASSERT_NOW(a_err_len_zero, rsp_valid && (rsp_beat.status != jves_pkg::ST_FOUND), rsp_beat.value_length == 16'd0, "error result carries a length")
   `JVES_ASSERT_ALWAYS(a_reset_empty, reset, !rsp_valid, "result shown right after reset")
   `JVES_ASSERT_NOW(a_rsp_cause, $rose(rsp_valid), $past(req_valid && req_ready, 2), "result without a byte two cycles before")

endmodule

bind json_value_extent_scanner jves_checker u_jves_checker (.*);

@@ test/json_value_extent_scanner_check.sv @@
module json_value_extent_scanner_check
   import jves_pkg::*;
#(
   parameter int LENGTH_BITS = jves_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_beat,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_type    rsp_beat,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   output int         fail_count,
   output int         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned LENGTH_MAX = (64'd1 << LENGTH_BITS) - 64'd1;
   localparam int REPORT_LIMIT = 10;

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_BARE,
      SCAN_TEXT,
      SCAN_TEXT_ESC,
      SCAN_NEST,
      SCAN_NEST_TEXT,
      SCAN_NEST_ESC
   } scan_state_type;

   scan_state_type  scan_state = SCAN_IDLE;
   logic [7:0]      depth_now = '0;
   logic [7:0]      depth_limit = MAX_DEPTH_RESET;
   longint unsigned length_now = 0;
   rsp_type         results_due[$];
   int              errors = 0;

   // comma, closing bracket or white space ends a bare scalar
   function automatic logic is_stop(input logic [7:0] c);
      return c == CHAR_COMMA || c == CHAR_RBRACE || c == CHAR_RBRACKET || c == CHAR_SPACE ||
             c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR;
   endfunction

   function automatic scan_result_type close_scan(input logic [2:0] code);
      scan_result_type res;
      res.emit = 1'b1;
      res.beat.status = code;
      res.beat.value_length = (code == ST_FOUND) ? length_now[15:0] : 16'd0;
      scan_state = SCAN_IDLE;
      depth_now = '0;
      length_now = 0;
      return res;
   endfunction

   // Advance the scan by one byte; return the result it ends with, if any.
   function automatic scan_result_type advance_scan(input req_type b);
      scan_result_type res;
      logic [7:0]      c;
      res = '0;
      c = b.data_byte;
      if (b.first_byte) begin
         depth_now = '0;
         length_now = 1;
         if (c == CHAR_QUOTE) begin
            scan_state = SCAN_TEXT;
         end else if (c == CHAR_LBRACE || c == CHAR_LBRACKET) begin
            if (depth_limit == 8'd0) return close_scan(ST_DEEP);
            depth_now = 8'd1;
            scan_state = SCAN_NEST;
         end else if (is_stop(c)) begin
            return close_scan(ST_EMPTY);
         end else begin
            scan_state = SCAN_BARE;
         end
      end else begin
         if (scan_state == SCAN_IDLE) return res;
         // the terminator is not part of the scalar, so it wins over the length check
         if (scan_state == SCAN_BARE && is_stop(c)) return close_scan(ST_FOUND);
         if (length_now >= LENGTH_MAX) return close_scan(ST_LONG);
         length_now = length_now + 1;
         case (scan_state)
            SCAN_TEXT: begin
               if (c == CHAR_BACKSLASH) scan_state = SCAN_TEXT_ESC;
               else if (c == CHAR_QUOTE) return close_scan(ST_FOUND);
            end
            SCAN_TEXT_ESC: scan_state = SCAN_TEXT;
            SCAN_NEST: begin
               if (c == CHAR_QUOTE) begin
                  scan_state = SCAN_NEST_TEXT;
               end else if (c == CHAR_LBRACE || c == CHAR_LBRACKET) begin
                  if (int'(depth_now) + 1 > int'(depth_limit)) return close_scan(ST_DEEP);
                  depth_now = depth_now + 8'd1;
               end else if (c == CHAR_RBRACE || c == CHAR_RBRACKET) begin
                  depth_now = depth_now - 8'd1;
                  if (depth_now == 8'd0) return close_scan(ST_FOUND);
               end
            end
            SCAN_NEST_TEXT: begin
               if (c == CHAR_BACKSLASH) scan_state = SCAN_NEST_ESC;
               else if (c == CHAR_QUOTE) scan_state = SCAN_NEST;
            end
            SCAN_NEST_ESC: scan_state = SCAN_NEST_TEXT;
            default: ;
         endcase
      end
      if (b.last_byte) return close_scan(scan_state == SCAN_BARE ? ST_FOUND : ST_ENDED);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type         want;
      scan_result_type step;
      if (reset) begin
         scan_state = SCAN_IDLE;
         depth_now = '0;
         length_now = 0;
         depth_limit = MAX_DEPTH_RESET;
         results_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("%0t: unexpected result beat: status %0d length %0d",
                           $time, rsp_beat.status, rsp_beat.value_length);
            end else begin
               want = results_due.pop_front();
               if (rsp_beat.status !== want.status ||
                   rsp_beat.value_length !== want.value_length) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display({"%0t: result mismatch: status %0d (expected %0d), ",
                               "length %0d (expected %0d)"},
                              $time, rsp_beat.status, want.status,
                              rsp_beat.value_length, want.value_length);
               end
            end
         end
         if (csr_write_enable) depth_limit = csr_write_data;
         if (req_valid && req_ready) begin
            step = advance_scan(req_beat);
            if (step.emit) results_due = {results_due, step.beat};
         end
      end
      fail_count <= errors;
      pending <= results_due.size();
   end

endmodule

@@ test/json_value_extent_scanner_test.sv @@
module json_value_extent_scanner_test;
   timeunit 1ns;
   timeprecision 1ps;
   import jves_pkg::*;

   localparam int STALL_PCT = 36;          // percent of cycles each side idles
   localparam int WATCHDOG_LIMIT = 2000;   // cycles with no beat moving on either channel
   localparam int DRAIN_CYCLES = 4;        // settle margin after the last expected result
   localparam int RANDOM_ITEMS = 420;

   // byte classes used to build text
   localparam string BARE_CHARS = "-0123456789tfnulraeE.+";
   localparam string STOPS = ",}] \t\n\r";
   localparam string BLANKS = " \t\n\r";
   localparam string OPENERS = "{[";
   localparam string CLOSERS = "}]";

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_beat = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_beat;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = '0;
   int         fail_count;
   int         pending;

   bit         steady = 1'b0;              // set: neither side idles
   int         depth_setting = MAX_DEPTH_RESET;
   int         quiet_cycles = 0;
   logic [7:0] text_q[$];                  // bytes of the scan being built

   json_value_extent_scanner uut (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_beat,
      .rsp_valid,
      .rsp_ready,
      .rsp_beat,
      .csr_write_enable,
      .csr_write_data
   );

   json_value_extent_scanner_check extent_check (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_beat,
      .rsp_valid,
      .rsp_ready,
      .rsp_beat,
      .csr_write_enable,
      .csr_write_data,
      .fail_count,
      .pending
   );

   always begin
      #5;
      clock = 1'b1;
      #5;
      clock = 1'b0;
   end

   // Stall the result channel at random, except in the steady stretch.
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= STALL_PCT);
   end

   // Abort if no beat moves for too long on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [7:0] pick(input string s);
      return s[$urandom_range(s.len() - 1)];
   endfunction

   // Add one byte at the tail of the text being built.
   function automatic void append_byte(input logic [7:0] c);
      text_q = {text_q, c};
   endfunction

   // Offer one beat and hold it until it is taken. Drop valid only for an idle gap.
   task automatic send_byte(input logic [7:0] data, input logic first, input logic last);
      while (!steady && $urandom_range(99) < STALL_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_beat  <= '{data_byte: data, first_byte: first, last_byte: last};
      do @(posedge clock); while (!req_ready);
   endtask

   // Send the built text: first flag on its opening byte, last flag at last_at (-1: none).
   task automatic send_text(input int last_at);
      foreach (text_q[i]) send_byte(text_q[i], i == 0, i == last_at);
   endtask

   task automatic send_string(input string s, input bit ends_text);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == 0, ends_text && i == s.len() - 1);
   endtask

   // Append a bare scalar or a quoted string with random escapes.
   function automatic void add_atom();
      int         n;
      logic [7:0] c;
      if ($urandom_range(1) == 0) begin
         n = $urandom_range(0, 5);
         append_byte(pick(BARE_CHARS));
         repeat (n) append_byte(pick(BARE_CHARS));
      end else begin
         n = $urandom_range(0, 8);
         append_byte(CHAR_QUOTE);
         repeat (n) begin
            if ($urandom_range(99) < 20) begin
               append_byte(CHAR_BACKSLASH);
               append_byte(8'($urandom_range(255)));
            end else begin
               c = 8'($urandom_range(255));
               // keep the string closed; a brace inside it must be skipped
               if (c == CHAR_QUOTE || c == CHAR_BACKSLASH) c = CHAR_LBRACE;
               append_byte(c);
            end
         end
         append_byte(CHAR_QUOTE);
      end
   endfunction

   // Append one value nesting at most `levels` deep: an atom, or a container
   // built from a random walk of opens, closes and members.
   function automatic void build_value(input int levels);
      int depth;
      if (levels == 0 || $urandom_range(99) < 45) begin
         add_atom();
         return;
      end
      append_byte(pick(OPENERS));
      depth = 1;
      // often dive straight to the target depth so the limit gets hit
      if ($urandom_range(3) == 0) begin
         while (depth < levels) begin
            append_byte(pick(OPENERS));
            depth++;
         end
      end
      repeat ($urandom_range(0, 10)) begin
         if (depth < levels && $urandom_range(99) < 35) begin
            append_byte(pick(OPENERS));
            depth++;
         end else if (depth > 1 && $urandom_range(99) < 30) begin
            append_byte(pick(CLOSERS));
            depth--;
         end else begin
            if ($urandom_range(99) < 25) append_byte(pick(BLANKS));
            add_atom();
            if ($urandom_range(99) < 60) append_byte(CHAR_COMMA);
            else if ($urandom_range(99) < 30) append_byte(8'h3A);
         end
      end
      // closers are mixed at random; the block does not tell them apart
      repeat (depth) append_byte(pick(CLOSERS));
   endfunction

   // Random scans: mostly well-formed values, some cut short, some raw noise.
   task automatic random_scans(input int budget);
      int sent;
      int r;
      int value_len;
      int last_at;
      int n;
      sent = 0;
      while (sent < budget) begin
         r = $urandom_range(99);
         text_q.delete();
         last_at = -1;
         if (r < 6) begin
            // empty scalar
            append_byte(pick(STOPS));
            value_len = 1;
            if ($urandom_range(1)) last_at = 0;
         end else if (r < 86) begin
            build_value($urandom_range(1, (depth_setting + 2 < 10) ? depth_setting + 2 : 10));
            value_len = text_q.size();
            if (r >= 72) begin
               // cut short: end the text there, or abandon it for the next scan
               value_len = $urandom_range(1, value_len);
               while (text_q.size() > value_len) void'(text_q.pop_back());
               if ($urandom_range(99) < 60) last_at = value_len - 1;
            end else if ($urandom_range(99) < 30) begin
               last_at = value_len - 1;
            end else begin
               // trailing bytes end a scalar, then are ignored
               n = $urandom_range(1, 3);
               repeat (n) append_byte(pick(STOPS));
               if ($urandom_range(99) < 20) last_at = text_q.size() - 1;
            end
         end else begin
            n = $urandom_range(1, 6);
            repeat (n)
               send_byte(8'($urandom_range(255)), $urandom_range(99) < 20,
                         $urandom_range(99) < 20);
            value_len = n;
         end
         send_text(last_at);
         sent += value_len;
      end
   endtask

   // Close any open scan with a beat that always gives a result, then let
   // every expected result drain and the pipeline settle.
   task automatic drain_phase();
      send_byte(8'($urandom_range(255)), 1'b1, 1'b1);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_depth(input int lim);
      depth_setting = lim;
      csr_write_enable <= 1'b1;
      csr_write_data <= 8'(lim);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int limits[6];
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed beats at the reset depth limit.
      send_string("7", 1'b1);                  // scalar closed by end of text
      for (int i = 0; i < STOPS.len(); i++)    // empty scalar on every stop byte
         send_byte(STOPS[i], 1'b1, 1'b0);
      send_string("\"a\\\"b\"", 1'b0);         // escaped quote inside a string
      send_string("\"ab", 1'b1);               // text ends inside a string
      send_string("\"a\\", 1'b1);              // text ends right after a backslash
      send_string("[{\"}\":[1]},\"\\\"]\"]", 1'b0);  // brackets inside strings skipped
      send_string("{]", 1'b0);                 // mismatched closer still closes
      send_string("[", 1'b1);                  // text ends inside a container
      send_string("[\"\\", 1'b1);              // ends after backslash in nested string
      send_byte("z", 1'b0, 1'b1);              // idle byte: ignored, last flag too
      send_string("[1", 1'b0);                 // abandoned by the next first byte
      send_string("2 ", 1'b0);
      send_byte(8'hFF, 1'b1, 1'b0);            // extreme byte values in a scalar
      send_byte(8'h00, 1'b0, 1'b1);
      send_string("\"ok\"", 1'b1);             // value ends on the last byte
      drain_phase();

      // Sweep the depth limit, extremes included; one stretch runs with no idling.
      limits = '{0, 1, 255, 2, 0, 8};
      limits[4] = $urandom_range(3, 12);
      foreach (limits[k]) begin
         steady = (limits[k] == 255);
         set_depth(limits[k]);
         // exactly at the limit: found; one deeper: refused
         text_q.delete();
         repeat (limits[k]) append_byte(pick(OPENERS));
         repeat (limits[k]) append_byte(pick(CLOSERS));
         send_text(-1);
         text_q.delete();
         repeat (limits[k] + 1) append_byte(pick(OPENERS));
         send_text(-1);
         random_scans(RANDOM_ITEMS / 6);
         drain_phase();
      end
      steady = 1'b0;

      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/jves_pkg.sv
sv/jves_scan.sv
sv/json_value_extent_scanner.sv
sv/jves_checker.sv
test/json_value_extent_scanner_check.sv
test/json_value_extent_scanner_test.sv
